### rtl/fqwh_pkg.sv
// Shared types and codes for the FIFO queue with waiter handoff.
// No dependencies; used by fqwh_cell, fqwh_row and the top level.
package fqwh_pkg;

    typedef enum logic [1:0] {
        FUNC_ENQ     = 2'd0,
        FUNC_DEQ     = 2'd1,
        FUNC_TRY_DEQ = 2'd2
    } func_t;

    typedef enum logic [2:0] {
        ST_STORED  = 3'd0,
        ST_HANDOFF = 3'd1,
        ST_SERVED  = 3'd2,
        ST_PARKED  = 3'd3,
        ST_EMPTY   = 3'd4,
        ST_DFULL   = 3'd5,
        ST_WFULL   = 3'd6
    } status_t;

    // Control seen by one storage cell
    typedef struct packed {
        logic shift;
        logic load;
    } cell_ctrl_t;

    // Control seen by one row of cells
    typedef struct packed {
        logic pop;
        logic push;
    } row_ctrl_t;

    localparam int unsigned SERVED_W = 32;

endpackage

### rtl/fifo_queue_with_waiter_handoff_unit.sv
// FIFO queue with waiter handoff. Every accepted item yields exactly one result
// item in the next cycle; a new item is taken each cycle as long as the result
// register is empty or being drained, so throughput is one item per cycle. Both
// cell rows are updated at the same clock edge as the result register.
// Enqueue (tuser 0) hands its word to the oldest parked requester if there is
// one, else stores it (or reports data full). Blocking dequeue (tuser 1) pops
// the oldest word, or parks the caller's ID (or reports waiters full). Try
// dequeue (tuser 2) pops or reports empty. Code 3 does nothing and reports
// empty. Results carry the counts after the operation and a saturating count
// of served dequeues. Both queues are rows of shifting cells with no reset;
// only written entries are ever read. No clearing pass is needed after reset.
// Depends on fqwh_pkg, fqwh_row, fqwh_cell.
module fifo_queue_with_waiter_handoff_unit #(
    parameter int unsigned DATA_DEPTH   = 16,
    parameter int unsigned WAITER_DEPTH = 8,
    parameter int unsigned DATA_WIDTH   = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // [31:0] data_in, [39:32] requester_id
    input  logic [1:0]  s_tuser,   // [1:0] func
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [87:0] m_tdata,   // [31:0] data_out, [39:32] dest_id,
                                   // [44:40] stored_count, [48:45] waiting_now,
                                   // [80:49] served_total, [87:81] zero
    output logic [2:0]  m_tuser    // [2:0] status
);

    localparam int unsigned DCW = $clog2(DATA_DEPTH + 1);
    localparam int unsigned WCW = $clog2(WAITER_DEPTH + 1);

    // ---------------------------------------------------------------
    // Handshake: advance when the result register is free or drains
    // ---------------------------------------------------------------
    logic fire;
    logic m_tvalid_reg;
    logic m_tvalid_next;

    assign s_tready = !m_tvalid_reg || m_tready;
    assign fire     = s_tvalid && s_tready;

    // ---------------------------------------------------------------
    // Input fields
    // ---------------------------------------------------------------
    logic [1:0]            func;
    logic [31:0]           data_in;
    logic [7:0]            requester_id;
    logic [63:0]           data_in_ext;
    logic [DATA_WIDTH-1:0] word;

    assign func         = s_tuser;
    assign data_in      = s_tdata[31:0];
    assign requester_id = s_tdata[39:32];
    // keep only DATA_WIDTH bits of the incoming word
    assign data_in_ext  = 64'(data_in);
    assign word         = data_in_ext[DATA_WIDTH-1:0];

    // ---------------------------------------------------------------
    // Control state
    // ---------------------------------------------------------------
    logic [DCW-1:0]               data_count_reg, data_count_next;
    logic [WCW-1:0]               waiter_count_reg, waiter_count_next;
    logic [fqwh_pkg::SERVED_W-1:0] served_reg, served_next;

    logic [DATA_WIDTH-1:0] data_head;
    logic [7:0]            waiter_head;

    fqwh_pkg::row_ctrl_t data_ctrl;
    fqwh_pkg::row_ctrl_t waiter_ctrl;

    // ---------------------------------------------------------------
    // Result payload (no reset)
    // ---------------------------------------------------------------
    fqwh_pkg::status_t     status_reg, status_next;
    logic [DATA_WIDTH-1:0] dout_reg, dout_next;
    logic [7:0]            dest_reg, dest_next;

    // Decode of the operation against the current counts
    logic data_empty, data_full, waiter_empty, waiter_full;
    logic bump;

    assign data_empty   = (data_count_reg == '0);
    assign data_full    = (data_count_reg == DCW'(DATA_DEPTH));
    assign waiter_empty = (waiter_count_reg == '0);
    assign waiter_full  = (waiter_count_reg == WCW'(WAITER_DEPTH));

    always_comb
    begin
        status_next       = fqwh_pkg::ST_EMPTY;
        dout_next         = '0;
        dest_next         = requester_id;
        data_ctrl         = '0;
        waiter_ctrl       = '0;
        bump              = 1'b0;
        data_count_next   = data_count_reg;
        waiter_count_next = waiter_count_reg;

        case (func)
            fqwh_pkg::FUNC_ENQ:
            begin
                if (!waiter_empty)
                begin
                    // hand the word straight to the oldest parked requester
                    status_next       = fqwh_pkg::ST_HANDOFF;
                    dout_next         = word;
                    dest_next         = waiter_head;
                    waiter_ctrl.pop   = 1'b1;
                    waiter_count_next = waiter_count_reg - 1'b1;
                    bump              = 1'b1;
                end
                else if (data_full)
                begin
                    // drop the word
                    status_next = fqwh_pkg::ST_DFULL;
                    dest_next   = '0;
                end
                else
                begin
                    status_next     = fqwh_pkg::ST_STORED;
                    dest_next       = '0;
                    data_ctrl.push  = 1'b1;
                    data_count_next = data_count_reg + 1'b1;
                end
            end
            fqwh_pkg::FUNC_DEQ, fqwh_pkg::FUNC_TRY_DEQ:
            begin
                if (!data_empty)
                begin
                    status_next     = fqwh_pkg::ST_SERVED;
                    dout_next       = data_head;
                    data_ctrl.pop   = 1'b1;
                    data_count_next = data_count_reg - 1'b1;
                    bump            = 1'b1;
                end
                else if (func == fqwh_pkg::FUNC_TRY_DEQ)
                begin
                    status_next = fqwh_pkg::ST_EMPTY;
                end
                else if (waiter_full)
                begin
                    // drop the park request
                    status_next = fqwh_pkg::ST_WFULL;
                end
                else
                begin
                    status_next       = fqwh_pkg::ST_PARKED;
                    waiter_ctrl.push  = 1'b1;
                    waiter_count_next = waiter_count_reg + 1'b1;
                end
            end
            default:
            begin
                status_next = fqwh_pkg::ST_EMPTY;
            end
        endcase

        // gate every state change on the handshake
        if (!fire)
        begin
            data_ctrl         = '0;
            waiter_ctrl       = '0;
            bump              = 1'b0;
            data_count_next   = data_count_reg;
            waiter_count_next = waiter_count_reg;
        end
    end

    // Saturating served count
    always_comb
    begin
        served_next = served_reg;
        if (bump && (served_reg != '1))
        begin
            served_next = served_reg + 1'b1;
        end
    end

    always_comb
    begin
        m_tvalid_next = m_tvalid_reg;
        if (fire)
        begin
            m_tvalid_next = 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            data_count_reg   <= '0;
            waiter_count_reg <= '0;
            served_reg       <= '0;
            m_tvalid_reg     <= 1'b0;
        end
        else
        begin
            data_count_reg   <= data_count_next;
            waiter_count_reg <= waiter_count_next;
            served_reg       <= served_next;
            m_tvalid_reg     <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            status_reg <= status_next;
            dout_reg   <= dout_next;
            dest_reg   <= dest_next;
        end
    end

    // ---------------------------------------------------------------
    // Storage rows
    // ---------------------------------------------------------------
    fqwh_row #(
        .DEPTH (DATA_DEPTH),
        .W     (DATA_WIDTH)
    ) u_data_row (
        .clk       (clk),
        .ctrl      (data_ctrl),
        .count     (data_count_reg),
        .load_data (word),
        .head      (data_head)
    );

    fqwh_row #(
        .DEPTH (WAITER_DEPTH),
        .W     (8)
    ) u_waiter_row (
        .clk       (clk),
        .ctrl      (waiter_ctrl),
        .count     (waiter_count_reg),
        .load_data (requester_id),
        .head      (waiter_head)
    );

    // ---------------------------------------------------------------
    // Output packing; counts reflect state after the item
    // ---------------------------------------------------------------
    logic [63:0] dout_ext;
    logic [31:0] dcount_ext;
    logic [31:0] wcount_ext;

    assign dout_ext   = 64'(dout_reg);
    assign dcount_ext = 32'(data_count_reg);
    assign wcount_ext = 32'(waiter_count_reg);

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = status_reg;
    assign m_tdata  = {7'd0, served_reg, wcount_ext[3:0], dcount_ext[4:0],
                       dest_reg, dout_ext[31:0]};

endmodule

### rtl/fqwh_cell.sv
// One storage cell of a shifting FIFO row: hold, take the neighbor's word, or load.
// Depends on fqwh_pkg (cell_ctrl_t).
module fqwh_cell #(
    parameter int unsigned W = 32
) (
    input  logic                  clk,
    input  fqwh_pkg::cell_ctrl_t  ctrl,
    input  logic [W-1:0]          load_data,
    input  logic [W-1:0]          shift_data,
    output logic [W-1:0]          data
);

    logic [W-1:0] data_reg;
    logic [W-1:0] data_next;

    always_comb
    begin
        data_next = data_reg;
        if (ctrl.load)
        begin
            data_next = load_data;
        end
        else if (ctrl.shift)
        begin
            data_next = shift_data;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule

### rtl/fqwh_row.sv
// A row of fqwh_cell forming a FIFO: oldest entry in cell 0, pop shifts toward it.
// Depends on fqwh_pkg and fqwh_cell; the fill count is kept by the caller.
module fqwh_row #(
    parameter int unsigned DEPTH = 8,
    parameter int unsigned W     = 8
) (
    input  logic                         clk,
    input  fqwh_pkg::row_ctrl_t          ctrl,
    input  logic [$clog2(DEPTH+1)-1:0]   count,
    input  logic [W-1:0]                 load_data,
    output logic [W-1:0]                 head
);

    localparam int unsigned CW = $clog2(DEPTH + 1);

    logic [W-1:0] cell_q   [DEPTH];
    logic [W-1:0] cell_nbr [DEPTH];

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        fqwh_pkg::cell_ctrl_t cc;

        if (i < DEPTH - 1)
        begin : g_mid
            assign cell_nbr[i] = cell_q[i+1];
        end
        else
        begin : g_end
            assign cell_nbr[i] = '0;
        end

        // push lands in the first free cell; pop advances every cell
        assign cc.shift = ctrl.pop;
        assign cc.load  = ctrl.push && (count == CW'(i));

        fqwh_cell #(
            .W (W)
        ) u_cell (
            .clk        (clk),
            .ctrl       (cc),
            .load_data  (load_data),
            .shift_data (cell_nbr[i]),
            .data       (cell_q[i])
        );
    end

    assign head = cell_q[0];

endmodule
